// ===== rtl/knn_pkg.sv =====
package knn_pkg;

	localparam int OP_W      = 2;
	localparam int IDX_W     = 4;
	localparam int VAL_W     = 24;
	localparam int POS_W     = 20;
	localparam int DIST_W    = 48;
	localparam int RANK_W    = 4;
	localparam int CNT_W     = 5;
	localparam int REG_IDX_W = 2;

	localparam int MAX_NEIGHBOURS_DEF = 16;
	localparam int MAX_VARS_DEF       = 16;
	localparam int POS_BITS_DEF       = 20;

	localparam logic [DIST_W-1:0] DIST_ALL_ONES = '1;

	localparam logic [REG_IDX_W-1:0] REG_NUM_VARS       = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_NUM_NEIGHBOURS = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DIST_MAX       = 2'd2;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_QUERY = 2'd1,
		OP_CAND  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [IDX_W-1:0]        elem_index;
		logic signed [VAL_W-1:0] value;
		logic [POS_W-1:0]        position;
	} req_item_t;

	typedef struct packed {
		logic [RANK_W-1:0] rank;
		logic              filled;
		logic [POS_W-1:0]  neighbour_position;
		logic [DIST_W-1:0] distance;
		logic              last;
	} rsp_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_MUL,
		ST_ACC,
		ST_CLAMP,
		ST_INS,
		ST_READ
	} state_t;

	typedef struct packed {
		logic clear;
		logic qwrite;
		logic capture;
		logic mag;
		logic mul;
		logic acc;
		logic clamp;
		logic insert;
		logic rd_start;
		logic rd_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic cand_ok;
		logic cand_end;
		logic rd_last;
		logic out_free;
	} dp_status_t;

	function automatic int addr_bits(input int depth);
		return (depth > 1) ? $clog2(depth) : 1;
	endfunction

	function automatic int count_bits(input int n);
		return $clog2(n + 1);
	endfunction

endpackage

// ===== rtl/knn_ram.sv =====
module knn_ram
	import knn_pkg::*;
#(
	parameter int WIDTH = VAL_W,
	parameter int DEPTH = MAX_VARS_DEF,
	localparam int AW   = addr_bits(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/knn_ctrl.sv =====
module knn_ctrl
	import knn_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  op_t        req_op,
	input  dp_status_t status,
	output logic       req_stall,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					unique case (req_op)
						OP_CAND:  state_n = status.cand_ok ? ST_MAG : ST_IDLE;
						OP_READ:  state_n = ST_READ;
						OP_CLEAR,
						OP_QUERY: state_n = ST_IDLE;
						default:  state_n = ST_IDLE;
					endcase
				end
			end
			ST_MAG:   state_n = ST_MUL;
			ST_MUL:   state_n = ST_ACC;
			ST_ACC:   state_n = status.cand_end ? ST_CLAMP : ST_IDLE;
			ST_CLAMP: state_n = ST_INS;
			ST_INS:   state_n = ST_IDLE;
			ST_READ: begin
				if (status.out_free && status.rd_last) begin
					state_n = ST_IDLE;
				end
			end
			default:  state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		logic take;
		take      = 1'b0;
		req_stall = 1'b1;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall    = 1'b0;
				take         = req_valid;
				cmd.clear    = take && (req_op == OP_CLEAR);
				cmd.qwrite   = take && (req_op == OP_QUERY);
				cmd.capture  = take && (req_op == OP_CAND);
				cmd.rd_start = take && (req_op == OP_READ);
			end
			ST_MAG:   cmd.mag = 1'b1;
			ST_MUL:   cmd.mul = 1'b1;
			ST_ACC:   cmd.acc = 1'b1;
			ST_CLAMP: cmd.clamp = 1'b1;
			ST_INS:   cmd.insert = 1'b1;
			ST_READ:  cmd.rd_load = status.out_free;
			default:  cmd = '0;
		endcase
	end

endmodule

// ===== rtl/knn_datapath.sv =====
module knn_datapath
	import knn_pkg::*;
#(
	parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
	parameter int MAX_VARS       = MAX_VARS_DEF,
	parameter int POS_BITS       = POS_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_cmd_t            cmd,
	output dp_status_t           status,
	input  req_item_t            req_item,
	input  logic                 rsp_stall,
	output logic                 rsp_valid,
	output rsp_item_t            rsp_item,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DIST_W-1:0]    cfg_data
);

	localparam int QA_W  = addr_bits(MAX_VARS);
	localparam int LA_W  = addr_bits(MAX_NEIGHBOURS);
	localparam int NN_W  = count_bits(MAX_NEIGHBOURS);
	localparam int NV_W  = count_bits(MAX_VARS);
	localparam int NNC_W = (NN_W > CNT_W) ? NN_W : CNT_W;
	localparam int NVC_W = (NV_W > CNT_W) ? NV_W : CNT_W;

	// configuration
	logic [CNT_W-1:0]  num_vars_q;
	logic [CNT_W-1:0]  num_neighbours_q;
	logic [DIST_W-1:0] dist_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q       <= CNT_W'(1);
			num_neighbours_q <= CNT_W'(1);
			dist_max_q       <= DIST_ALL_ONES;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_VARS:       num_vars_q       <= cfg_data[CNT_W-1:0];
				REG_NUM_NEIGHBOURS: num_neighbours_q <= cfg_data[CNT_W-1:0];
				REG_DIST_MAX:       dist_max_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [NVC_W-1:0] nv_ext;
	logic [NVC_W-1:0] nv_used;
	logic [NNC_W-1:0] nn_ext;
	logic [NNC_W-1:0] nn_used;
	logic [NVC_W-1:0] idx_ext;

	always_comb begin
		nv_ext = NVC_W'(num_vars_q);
		if (nv_ext == '0) begin
			nv_used = NVC_W'(1);
		end else if (nv_ext > NVC_W'(MAX_VARS)) begin
			nv_used = NVC_W'(MAX_VARS);
		end else begin
			nv_used = nv_ext;
		end
		nn_ext = NNC_W'(num_neighbours_q);
		if (nn_ext == '0) begin
			nn_used = NNC_W'(1);
		end else if (nn_ext > NNC_W'(MAX_NEIGHBOURS)) begin
			nn_used = NNC_W'(MAX_NEIGHBOURS);
		end else begin
			nn_used = nn_ext;
		end
	end

	assign idx_ext = NVC_W'(req_item.elem_index);

	// query vector store
	logic [QA_W-1:0]  q_addr;
	logic             q_we;
	logic [VAL_W-1:0] q_rdata;

	assign q_addr = QA_W'(req_item.elem_index);
	assign q_we   = cmd.qwrite && (idx_ext < NVC_W'(MAX_VARS));

	knn_ram #(
		.WIDTH (VAL_W),
		.DEPTH (MAX_VARS)
	) u_qram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_addr),
		.wdata (req_item.value),
		.re    (cmd.capture),
		.raddr (q_addr),
		.rdata (q_rdata)
	);

	// candidate element path
	logic [VAL_W-1:0]   val_q;
	logic [POS_W-1:0]   pos_q;
	logic               first_q;
	logic               end_q;
	logic [VAL_W-1:0]   mag_q;
	logic [DIST_W-1:0]  sq_q;
	logic [DIST_W-1:0]  acc_q;
	logic [DIST_W-1:0]  dst_q;

	logic [VAL_W:0]     diff;
	logic [VAL_W:0]     diff_neg;
	logic [VAL_W-1:0]   mag;
	logic [2*VAL_W-1:0] prod;
	logic [DIST_W-1:0]  acc_base;
	logic [DIST_W:0]    acc_sum;

	assign diff     = {val_q[VAL_W-1], val_q} - {q_rdata[VAL_W-1], q_rdata};
	assign diff_neg = ~diff + (VAL_W+1)'(1);
	assign mag      = diff[VAL_W] ? diff_neg[VAL_W-1:0] : diff[VAL_W-1:0];
	assign prod     = mag_q * mag_q;
	assign acc_base = first_q ? '0 : acc_q;
	assign acc_sum  = {1'b0, acc_base} + {1'b0, sq_q};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			val_q   <= req_item.value;
			pos_q   <= req_item.position;
			first_q <= (req_item.elem_index == '0);
			end_q   <= (idx_ext == nv_used - NVC_W'(1));
		end
		if (cmd.mag) begin
			mag_q <= mag;
		end
		if (cmd.mul) begin
			sq_q <= DIST_W'(prod);
		end
		if (cmd.clamp) begin
			dst_q <= (acc_q > dist_max_q) ? dist_max_q : acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (cmd.clear) begin
			acc_q <= '0;
		end else if (cmd.acc) begin
			acc_q <= acc_sum[DIST_W] ? DIST_ALL_ONES : acc_sum[DIST_W-1:0];
		end
	end

	// sorted list cells
	logic [DIST_W-1:0]   dist_q  [MAX_NEIGHBOURS];
	logic [POS_BITS-1:0] lpos_q  [MAX_NEIGHBOURS];
	logic                valid_q [MAX_NEIGHBOURS];

	logic [DIST_W-1:0]   prev_dist  [MAX_NEIGHBOURS];
	logic [POS_BITS-1:0] prev_pos   [MAX_NEIGHBOURS];
	logic                prev_valid [MAX_NEIGHBOURS];
	logic [MAX_NEIGHBOURS-1:0] in_rng;
	logic [MAX_NEIGHBOURS-1:0] ge;
	logic [MAX_NEIGHBOURS-1:0] shift_in;
	logic [POS_BITS-1:0] new_pos;

	assign new_pos = POS_BITS'(pos_q);

	always_comb begin
		for (int k = 0; k < MAX_NEIGHBOURS; k++) begin
			in_rng[k] = NNC_W'(k) < nn_used;
			ge[k]     = in_rng[k] && (dst_q <= dist_q[k]);
		end
		prev_dist[0]  = dst_q;
		prev_pos[0]   = new_pos;
		prev_valid[0] = 1'b1;
		shift_in[0]   = 1'b0;
		for (int k = 1; k < MAX_NEIGHBOURS; k++) begin
			prev_dist[k]  = dist_q[k-1];
			prev_pos[k]   = lpos_q[k-1];
			prev_valid[k] = valid_q[k-1];
			shift_in[k]   = ge[k-1] && in_rng[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_NEIGHBOURS; k++) begin
				dist_q[k]  <= DIST_ALL_ONES;
				lpos_q[k]  <= '0;
				valid_q[k] <= 1'b0;
			end
		end else if (cmd.clear) begin
			for (int k = 0; k < MAX_NEIGHBOURS; k++) begin
				dist_q[k]  <= dist_max_q;
				lpos_q[k]  <= '0;
				valid_q[k] <= 1'b0;
			end
		end else if (cmd.insert) begin
			for (int k = 0; k < MAX_NEIGHBOURS; k++) begin
				if (shift_in[k]) begin
					dist_q[k]  <= prev_dist[k];
					lpos_q[k]  <= prev_pos[k];
					valid_q[k] <= prev_valid[k];
				end else if (ge[k]) begin
					dist_q[k]  <= dst_q;
					lpos_q[k]  <= new_pos;
					valid_q[k] <= 1'b1;
				end
			end
		end
	end

	// read-out
	logic [LA_W-1:0] rd_q;
	logic            rsp_valid_q;
	rsp_item_t       rsp_q;
	logic            rd_last;
	logic            out_free;

	assign rd_last  = (NNC_W'(rd_q) == nn_used - NNC_W'(1));
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q        <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.rd_start) begin
				rd_q <= '0;
			end else if (cmd.rd_load) begin
				rd_q <= rd_q + LA_W'(1);
			end
			if (cmd.rd_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_load) begin
			rsp_q.rank               <= RANK_W'(rd_q);
			rsp_q.filled             <= valid_q[rd_q];
			rsp_q.neighbour_position <= POS_W'(lpos_q[rd_q]);
			rsp_q.distance           <= dist_q[rd_q];
			rsp_q.last               <= rd_last;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	assign status.cand_ok  = idx_ext < nv_used;
	assign status.cand_end = end_q;
	assign status.rd_last  = rd_last;
	assign status.out_free = out_free;

endmodule

// ===== rtl/knn_top_k_distance_select.sv =====
// k-nearest-neighbour selector with squared Euclidean distance. Ops: clear list,
// load a query element into the query store, stream a candidate element, read the
// list. A candidate element passes through query store read, difference, 24x24
// multiply and accumulate; the last element of a candidate adds the clamp to
// dist_max and one insertion step in which every list cell within num_neighbours
// compares and shifts in parallel. A read-out sends one item per cycle out of the
// response register while the response side does not stall. Requests are taken
// one at a time; stall is high while a request is in progress. Configuration must
// be written only while idle; the block itself does not enforce this.
module knn_top_k_distance_select
	import knn_pkg::*;
#(
	parameter int MAX_NEIGHBOURS = MAX_NEIGHBOURS_DEF,
	parameter int MAX_VARS       = MAX_VARS_DEF,
	parameter int POS_BITS       = POS_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_item_t            req_item,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_item_t            rsp_item,
	input  logic                 cfg_we,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [DIST_W-1:0]    cfg_data
);

	ctrl_cmd_t  cmd;
	dp_status_t status;

	knn_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req_item.op),
		.status    (status),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	knn_datapath #(
		.MAX_NEIGHBOURS (MAX_NEIGHBOURS),
		.MAX_VARS       (MAX_VARS),
		.POS_BITS       (POS_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.req_item  (req_item),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_item  (rsp_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req_item.op == OP_READ) |=> req_stall)
		else $error("read-out request not held off");

	a_rank_step: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_stall && !rsp_item.last) |=>
		(!rsp_valid || rsp_item.rank == $past(rsp_item.rank) + RANK_W'(1)))
		else $error("read-out rank out of sequence");

	a_empty_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_item.filled) |-> (rsp_item.neighbour_position == '0))
		else $error("empty entry carries a position");

endmodule

// ===== test/tb_knn_top_k_distance_select.sv =====
module tb_knn_top_k_distance_select;
	import knn_pkg::*;

	localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam int IDLE_LIMIT = 3000;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_item_t            req_item = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_item_t            rsp_item;
	logic                 cfg_we = 1'b0;
	logic [REG_IDX_W-1:0] cfg_index = '0;
	logic [DIST_W-1:0]    cfg_data = '0;

	req_item_t ops_to_send [$];
	rsp_item_t list_rows_due [$];
	int items_queued = 0;
	int items_taken = 0;
	int rows_predicted = 0;
	int rows_checked = 0;
	int error_count = 0;
	int tx_gap = 0;
	int rx_hold = 0;
	int idle_cycles = 0;
	bit offer_next;
	bit calm_tx = 1'b0;
	bit calm_rx = 1'b0;
	bit long_hold_done = 1'b0;

	// predicted block state
	logic [CNT_W-1:0]        cfg_vars = CNT_W'(1);
	logic [CNT_W-1:0]        cfg_nbrs = CNT_W'(1);
	logic [DIST_W-1:0]       cfg_dmax = DIST_ALL_ONES;
	logic signed [VAL_W-1:0] q_vec [MAX_VARS_DEF];
	longint unsigned         dist_acc;
	logic [DIST_W-1:0]       nb_dist [MAX_NEIGHBOURS_DEF];
	logic [POS_W-1:0]        nb_pos [MAX_NEIGHBOURS_DEF];
	logic                    nb_full [MAX_NEIGHBOURS_DEF];

	// stimulus side view of the query and the last candidate
	logic signed [VAL_W-1:0] q_plan [MAX_VARS_DEF];
	logic signed [VAL_W-1:0] prev_cand [MAX_VARS_DEF];

	knn_top_k_distance_select dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_item  (req_item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_item  (rsp_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic int used_cnt(input logic [CNT_W-1:0] v);
		if (v < 1) return 1;
		if (v > 16) return 16;
		return int'(v);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [POS_W-1:0] pick_pos();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		default: return POS_W'($urandom);
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_elem(input int e);
		case ($urandom_range(0, 9))
		0, 1, 2, 3: return q_plan[e] + VAL_W'($urandom_range(0, 64)) - VAL_W'(32);
		4, 5: return VAL_W'($urandom);
		6: return q_plan[e][VAL_W-1] ? VAL_MAX : VAL_MIN;
		7: return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
		default: return prev_cand[e];
		endcase
	endfunction

	function automatic void push_op(input op_t op, input int idx,
			input logic [VAL_W-1:0] val, input logic [POS_W-1:0] pos);
		req_item_t it;
		it.op = op;
		it.elem_index = IDX_W'(idx);
		it.value = val;
		it.position = pos;
		ops_to_send.push_back(it);
		items_queued++;
	endfunction

	function automatic void wipe_list();
		for (int k = 0; k < MAX_NEIGHBOURS_DEF; k++) begin
			nb_dist[k] = cfg_dmax;
			nb_pos[k] = '0;
			nb_full[k] = 1'b0;
		end
		dist_acc = 0;
	endfunction

	task automatic flag_error(input string what, input longint unsigned got,
			input longint unsigned want);
		error_count++;
		$display("mismatch in %s at %0t: got 0x%0h, want 0x%0h", what, $time, got, want);
	endtask

	task automatic apply_knn_op(input req_item_t it);
		int nv, nn, r, idx;
		longint diff;
		longint unsigned sq, dst;
		rsp_item_t row;
		nv = used_cnt(cfg_vars);
		nn = used_cnt(cfg_nbrs);
		idx = int'(it.elem_index);
		case (it.op)
		OP_CLEAR: wipe_list();
		OP_QUERY: q_vec[idx] = it.value;
		OP_CAND: begin
			if (idx < nv) begin
				diff = longint'($signed(it.value)) - longint'($signed(q_vec[idx]));
				if (diff < 0) diff = -diff;
				sq = $unsigned(diff) * $unsigned(diff);
				dist_acc = (idx == 0) ? sq : dist_acc + sq;
				if (dist_acc > 64'(DIST_ALL_ONES)) dist_acc = 64'(DIST_ALL_ONES);
				if (idx == nv - 1) begin
					dst = (dist_acc > cfg_dmax) ? cfg_dmax : dist_acc;
					r = 0;
					while (r < nn && dst > nb_dist[r]) r++;
					if (r < nn) begin
						for (int k = nn - 1; k > r; k--) begin
							nb_dist[k] = nb_dist[k-1];
							nb_pos[k] = nb_pos[k-1];
							nb_full[k] = nb_full[k-1];
						end
						nb_dist[r] = dst[DIST_W-1:0];
						nb_pos[r] = it.position;
						nb_full[r] = 1'b1;
					end
				end
			end
		end
		OP_READ: begin
			for (int k = 0; k < nn; k++) begin
				row.rank = RANK_W'(k);
				row.filled = nb_full[k];
				row.neighbour_position = nb_pos[k];
				row.distance = nb_dist[k];
				row.last = (k == nn - 1);
				list_rows_due.push_back(row);
				rows_predicted++;
			end
		end
		endcase
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [DIST_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
		REG_NUM_VARS: cfg_vars = val[CNT_W-1:0];
		REG_NUM_NEIGHBOURS: cfg_nbrs = val[CNT_W-1:0];
		REG_DIST_MAX: cfg_dmax = val;
		default: ;
		endcase
	endtask

	task automatic settle(input int extra);
		wait (items_taken == items_queued && rows_checked == rows_predicted);
		repeat (extra) @(posedge clk);
	endtask

	task automatic gen_phase(input int nv, input int n);
		int stop, r, m;
		bit copy_prev;
		logic [POS_W-1:0] pos;
		stop = items_queued + n;
		while (items_queued < stop) begin
			r = $urandom_range(0, 99);
			if (r < 5) begin
				push_op(OP_CLEAR, $urandom_range(0, 15), VAL_W'($urandom), pick_pos());
			end else if (r < 12) begin
				m = $urandom_range(0, MAX_VARS_DEF - 1);
				q_plan[m] = pick_elem(m);
				push_op(OP_QUERY, m, q_plan[m], pick_pos());
			end else if (r < 20) begin
				// stray element or a candidate cut short
				if ($urandom_range(0, 1)) begin
					m = $urandom_range(0, 15);
					push_op(OP_CAND, m, pick_elem(m), pick_pos());
				end else begin
					m = $urandom_range(0, nv - 1);
					pos = pick_pos();
					for (int e = 0; e < m; e++) push_op(OP_CAND, e, pick_elem(e), pos);
				end
			end else if (r < 34) begin
				push_op(OP_READ, $urandom_range(0, 15), VAL_W'($urandom), pick_pos());
			end else begin
				pos = pick_pos();
				copy_prev = ($urandom_range(0, 3) == 0);
				for (int e = 0; e < nv; e++) begin
					if (!copy_prev) prev_cand[e] = pick_elem(e);
					push_op(OP_CAND, e, prev_cand[e], pos);
				end
			end
		end
	endtask

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			offer_next = !req_valid;
			if (req_valid && !req_stall) begin
				apply_knn_op(req_item);
				items_taken++;
				tx_gap = calm_tx ? 0 : pick_gap();
				offer_next = 1'b1;
			end
			if (offer_next) begin
				if (tx_gap > 0) begin
					tx_gap--;
					req_valid <= 1'b0;
				end else if (ops_to_send.size() > 0) begin
					req_item <= ops_to_send.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// response stall, with one long hold once the list read-outs are flowing
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (rx_hold > 0) begin
			rx_hold--;
			rsp_stall <= 1'b1;
		end else if (!long_hold_done && rows_checked >= 8 && rsp_valid && !rsp_item.last) begin
			long_hold_done = 1'b1;
			rx_hold = 119;
			rsp_stall <= 1'b1;
		end else begin
			rx_hold = calm_rx ? 0 : pick_gap();
			rsp_stall <= (rx_hold > 0);
			if (rx_hold > 0) rx_hold--;
		end
	end

	// response monitor
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (list_rows_due.size() == 0) begin
				flag_error("unexpected item, rank", rsp_item.rank, 0);
			end else begin
				want = list_rows_due.pop_front();
				if (rsp_item.rank !== want.rank)
					flag_error("rank", rsp_item.rank, want.rank);
				if (rsp_item.filled !== want.filled)
					flag_error("filled", rsp_item.filled, want.filled);
				if (rsp_item.neighbour_position !== want.neighbour_position)
					flag_error("neighbour_position", rsp_item.neighbour_position,
						want.neighbour_position);
				if (rsp_item.distance !== want.distance)
					flag_error("distance", rsp_item.distance, want.distance);
				if (rsp_item.last !== want.last)
					flag_error("last", rsp_item.last, want.last);
				rows_checked++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		logic [CNT_W-1:0] nv_w, nn_w;
		logic [DIST_W-1:0] dm_w;
		int n_items;
		arst_n = 1'b0;
		wipe_list();
		for (int e = 0; e < MAX_VARS_DEF; e++) prev_cand[e] = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		push_op(OP_READ, 0, '0, '0);
		for (int e = 0; e < MAX_VARS_DEF; e++) begin
			case (e)
			0: q_plan[e] = VAL_MIN;
			1: q_plan[e] = VAL_MAX;
			2: q_plan[e] = '0;
			3: q_plan[e] = '1;
			default: q_plan[e] = VAL_W'($urandom);
			endcase
			push_op(OP_QUERY, e, q_plan[e], POS_W'(e));
		end
		push_op(OP_CAND, 0, VAL_MAX, '1);
		push_op(OP_CAND, 9, VAL_MIN, '0);
		push_op(OP_READ, 15, '0, '0);
		push_op(OP_CAND, 0, VAL_MIN, POS_W'(5));
		push_op(OP_READ, 0, VAL_MAX, '1);
		push_op(OP_CLEAR, 15, VAL_MAX, '1);
		push_op(OP_READ, 0, '0, '0);
		settle(12);

		for (int p = 0; p < 8; p++) begin
			n_items = 24;
			case (p)
			0: begin
				nv_w = CNT_W'(16); nn_w = CNT_W'(16); dm_w = DIST_ALL_ONES; n_items = 50;
			end
			1: begin
				nv_w = '0; nn_w = '0; dm_w = '0;
			end
			2: begin
				nv_w = CNT_W'(31); nn_w = CNT_W'(31);
				dm_w = DIST_W'($urandom_range(0, 1 << 24));
				n_items = 40;
			end
			3: begin
				nv_w = CNT_W'(1); nn_w = CNT_W'(16); dm_w = DIST_ALL_ONES;
			end
			default: begin
				nv_w = CNT_W'($urandom_range(1, 5));
				nn_w = CNT_W'($urandom_range(1, 16));
				dm_w = $urandom_range(0, 1) ? DIST_W'({$urandom, $urandom})
					: DIST_W'($urandom_range(0, 1 << 20));
			end
			endcase
			calm_tx = ($urandom_range(0, 3) == 0);
			calm_rx = ($urandom_range(0, 3) == 0);
			write_reg(REG_NUM_VARS, DIST_W'(nv_w));
			write_reg(REG_NUM_NEIGHBOURS, DIST_W'(nn_w));
			write_reg(REG_DIST_MAX, dm_w);
			// two full read-outs back to back so the long hold backs up the input
			if (p == 0) begin
				push_op(OP_READ, 0, '0, '0);
				push_op(OP_READ, 0, '0, '0);
			end
			gen_phase(used_cnt(nv_w), n_items);
			settle(12);
		end

		settle(20);
		if (error_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
